// ----- hdl/keyed_count_table_macros.svh -----
`ifndef KEYED_COUNT_TABLE_MACROS_SVH
`define KEYED_COUNT_TABLE_MACROS_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define KCT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define KCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/kct_pkg.sv -----
`default_nettype none

package kct_pkg;

  // Default table depth
  localparam int ENTRIES_DEF = 16;

  localparam int KEY_W   = 32;
  localparam int QTY_W   = 32;
  localparam int COUNT_W = 31;

  // Request opcodes; the fourth code is undefined and is rejected
  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_CONSUME = 2'd1,
    OP_QUERY   = 2'd2
  } kct_op_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_CHANGED  = 3'd0,
    ST_OK       = 3'd1,
    ST_REJECTED = 3'd2,
    ST_MISSING  = 3'd3,
    ST_FULL     = 3'd4
  } kct_status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_LOOKUP = 2'd1,
    S_UPDATE = 2'd2
  } kct_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // capture the incoming request
    logic lookup;  // register key match and free-slot search
    logic commit;  // write the table and load the result register
  } kct_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/kct_ctrl.sv -----
`default_nettype none
`include "keyed_count_table_macros.svh"

module kct_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output kct_pkg::kct_cmd_t     cmd
);
  import kct_pkg::*;

  kct_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       commit;
  logic       accept;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Commit once the result register is free or being drained
  assign commit = (state_r == S_UPDATE) && (!out_valid_r || out_tready);

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd.lookup = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.commit = commit;
        // a new request may enter on the commit cycle
        in_tready  = commit;
        if (commit) state_nxt = in_tvalid ? S_LOOKUP : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // capture the request on its accepting edge
    cmd.load = in_tvalid && in_tready;
  end

  assign accept = in_tvalid && in_tready;

  // Result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  assign out_tvalid = out_valid_r;

  `KCT_ASSERT_NOW(a_no_accept_in_lookup, state_r == S_LOOKUP, !in_tready, "accept during lookup")
  `KCT_ASSERT_NOW(a_rise_after_update, $rose(out_valid_r), $past(state_r == S_UPDATE), "result without update")
  `KCT_ASSERT_NEXT(a_accept_to_lookup, accept, state_r == S_LOOKUP, "accepted request not looked up")

endmodule

`default_nettype wire

// ----- hdl/kct_dp.sv -----
`default_nettype none
`include "keyed_count_table_macros.svh"

module kct_dp #(
  parameter int ENTRIES = kct_pkg::ENTRIES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire kct_pkg::kct_cmd_t          cmd,
  input  wire logic [1:0]                 in_opcode,
  input  wire logic [kct_pkg::KEY_W-1:0]  in_key,
  input  wire logic [kct_pkg::QTY_W-1:0]  in_qty,
  input  wire logic                       in_auto,
  output logic [2:0]                      res_status,
  output logic [kct_pkg::COUNT_W-1:0]     res_count,
  output logic                            res_changed
);
  import kct_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Slot storage: keys need no reset, valid bits do
  logic [KEY_W-1:0]   key_mem [ENTRIES];
  logic [COUNT_W-1:0] cnt_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;

  // Captured request
  logic [1:0]       op_r;
  logic [KEY_W-1:0] key_r;
  logic [QTY_W-1:0] qty_r;
  logic             auto_r;

  // Lookup stage
  logic [ENTRIES-1:0] match;
  logic [IDX_W-1:0]   hit_idx_c, free_idx_c;
  logic               hit_c, free_ok_c;
  logic               hit_r, free_ok_r;
  logic [IDX_W-1:0]   hit_idx_r, free_idx_r;
  logic [COUNT_W-1:0] cur_r;

  // Update stage
  logic               positive;
  logic [COUNT_W-1:0] q31;
  logic [COUNT_W:0]   sum_c;
  logic [COUNT_W-1:0] sat_c, left_c;
  logic               wr_en, wr_valid, ins_en, take_en;
  logic [IDX_W-1:0]   wr_idx;
  logic [COUNT_W-1:0] wr_cnt;
  kct_status_t        st_c;
  logic [COUNT_W-1:0] cnt_c;
  logic               chg_c;

  kct_status_t        out_status_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_changed_r;

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_opcode;
      key_r  <= in_key;
      qty_r  <= in_qty;
      auto_r <= in_auto;
    end
  end

  // Parallel key compare
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (key_mem[i] == key_r);
    end
  end

  // Lowest matching slot and lowest free slot
  always_comb begin
    hit_idx_c  = '0;
    free_idx_c = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) hit_idx_c = IDX_W'(i);
      if (!valid_r[i]) free_idx_c = IDX_W'(i);
    end
  end

  assign hit_c     = |match;
  assign free_ok_c = ~&valid_r;

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit_r      <= hit_c;
      hit_idx_r  <= hit_idx_c;
      free_ok_r  <= free_ok_c;
      free_idx_r <= free_idx_c;
      cur_r      <= hit_c ? cnt_mem[hit_idx_c] : '0;
    end
  end

  // Quantity checks and arithmetic
  assign positive = (qty_r != '0) && !qty_r[QTY_W-1];
  assign q31      = qty_r[COUNT_W-1:0];
  assign sum_c    = {1'b0, cur_r} + {1'b0, q31};
  assign sat_c    = sum_c[COUNT_W] ? {COUNT_W{1'b1}} : sum_c[COUNT_W-1:0];
  assign left_c   = cur_r - q31;

  // Operation decode
  always_comb begin
    st_c     = ST_REJECTED;
    cnt_c    = '0;
    chg_c    = 1'b0;
    ins_en   = 1'b0;
    take_en  = 1'b0;
    wr_en    = 1'b0;
    wr_idx   = hit_idx_r;
    wr_cnt   = sat_c;
    wr_valid = 1'b1;
    case (kct_op_t'(op_r))
      OP_ADD: begin
        if (!auto_r) begin
          st_c = ST_REJECTED;
        end else if (!positive) begin
          st_c  = ST_OK;
          cnt_c = cur_r;
        end else if (!hit_r) begin
          if (!free_ok_r) begin
            st_c = ST_FULL;
          end else begin
            ins_en = 1'b1;
            wr_en  = 1'b1;
            wr_idx = free_idx_r;
            wr_cnt = q31;
            st_c   = ST_CHANGED;
            cnt_c  = q31;
            chg_c  = 1'b1;
          end
        end else begin
          wr_en = 1'b1;
          st_c  = ST_CHANGED;
          cnt_c = sat_c;
          chg_c = 1'b1;
        end
      end
      OP_CONSUME: begin
        if (!positive) begin
          st_c  = ST_OK;
          cnt_c = cur_r;
        end else if (!hit_r || (cur_r < q31)) begin
          st_c  = ST_MISSING;
          cnt_c = cur_r;
        end else begin
          take_en  = 1'b1;
          wr_en    = 1'b1;
          wr_cnt   = left_c;
          wr_valid = (left_c != '0);
          st_c     = ST_CHANGED;
          cnt_c    = left_c;
          chg_c    = 1'b1;
        end
      end
      OP_QUERY: begin
        st_c  = ST_OK;
        cnt_c = cur_r;
      end
      default: begin
        st_c = ST_REJECTED;
      end
    endcase
  end

  // Table write
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      key_mem[wr_idx] <= key_r;
      cnt_mem[wr_idx] <= wr_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit && wr_en) begin
      valid_r[wr_idx] <= wr_valid;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r  <= st_c;
      out_count_r   <= cnt_c;
      out_changed_r <= chg_c;
    end
  end

  assign res_status  = out_status_r;
  assign res_count   = out_count_r;
  assign res_changed = out_changed_r;

  `KCT_ASSERT_NOW(a_insert_free, cmd.commit && ins_en, !valid_r[free_idx_r], "insert into used slot")
  `KCT_ASSERT_NOW(a_take_hit, cmd.commit && take_en, hit_r && valid_r[hit_idx_r], "consume of absent slot")
  `KCT_ASSERT_NEXT(a_chg_status, cmd.commit, out_changed_r == (out_status_r == ST_CHANGED), "changed flag mismatch")

endmodule

`default_nettype wire

// ----- hdl/keyed_count_table.sv -----
// Keyed count table: up to ENTRIES slots, each holding a 32-bit key and a
// saturating 31-bit count. Requests are add, consume and query; each request
// gives one result with status, count after the operation and a changed flag.
// A request passes a lookup state, which compares the key against every slot
// in parallel and finds the lowest free slot, and then an update state for the
// read-modify-write of the chosen slot, which also loads the result register.
// A new request can be taken in the same cycle as the previous one commits,
// as long as results are drained; a stalled result holds the table after one
// more request has been captured. Slot valid bits clear at reset; no clearing pass.
`default_nettype none

module keyed_count_table #(
  parameter int ENTRIES = kct_pkg::ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // item_key[31:0], quantity[63:32]
  input  wire logic [2:0]  in_tuser,   // opcode[1:0], auto_stored[2]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // count[30:0], zero[31]
  output logic [3:0]       out_tuser   // status[2:0], changed[3]
);
  import kct_pkg::*;

  kct_cmd_t           cmd;
  logic [2:0]         res_status;
  logic [COUNT_W-1:0] res_count;
  logic               res_changed;

  kct_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  kct_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_opcode   (in_tuser[1:0]),
    .in_key      (in_tdata[31:0]),
    .in_qty      (in_tdata[63:32]),
    .in_auto     (in_tuser[2]),
    .res_status  (res_status),
    .res_count   (res_count),
    .res_changed (res_changed)
  );

  assign out_tdata = {1'b0, res_count};
  assign out_tuser = {res_changed, res_status};

endmodule

`default_nettype wire
